>>> rtl/core/vibe_background_segmenter_core_assert.svh
// Assertion macros used by the checker file.
`ifndef VIBE_BACKGROUND_SEGMENTER_CORE_ASSERT_SVH
`define VIBE_BACKGROUND_SEGMENTER_CORE_ASSERT_SVH
`define VBS_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define VBS_ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("assertion failed");
`endif

>>> rtl/core/vbs_pkg.sv
package vbs_pkg;
    localparam int Samples = 16;
    localparam int MaxWidth = 64;
    localparam int MaxHeight = 64;
    localparam int SlotW = $clog2(Samples);
    localparam int XW = $clog2(MaxWidth);
    localparam int YW = $clog2(MaxHeight);
    localparam int AddrW = XW + YW + SlotW;
    localparam int CntW = $clog2(Samples + 1);
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;
    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_MIN = 3'd1;
    localparam logic [2:0] REG_SUBSAMPLE = 3'd2;
    localparam logic [2:0] REG_WIDTH = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    typedef struct packed {
        logic [8:0] match_radius;
        logic [4:0] min_matches;
        logic [6:0] frame_width;
        logic [6:0] frame_height;
    } cfg_t;

    function automatic logic [17:0] dist_sq(input logic [23:0] a, input logic [23:0] b);
        logic [7:0] dr;
        logic [7:0] dg;
        logic [7:0] db;
        dr = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
        dg = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
        db = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
        return 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);
    endfunction
endpackage

>>> rtl/core/vibe_background_segmenter_core.sv
// Background segmenter with a per-pixel model of sixteen stored colors.
// Input requests arrive on in_valid/in_stall with the pixel fields; result
// requests leave on out_valid/out_stall with is_foreground and match_count.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// The block works on one request at a time. A request outside the frame goes
// straight to S_DONE, from which its result moves into the output register;
// a load, or a segment request when min_matches is zero, passes through
// S_SELF and S_NEIGH before S_DONE. A segment request otherwise reads the
// stored colors of its pixel one per cycle from the sample memory, stopping
// once min_matches have matched or all sixteen are read, and then passes
// through S_SELF and S_NEIGH, the states of the two possible write-backs.
// The next request is taken once the result is in the output register.
// The result waits there while the receiver stalls, and the block
// keeps working on the following request until that one is finished.
// Reset returns the registers to their default values and empties the
// output register; the sample memory is not cleared, and a pixel must be
// loaded before it is segmented.
module vibe_background_segmenter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [5:0] x,
    input  logic [5:0] y,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [3:0] load_slot,
    input  logic [7:0] self_draw,
    input  logic [3:0] self_slot,
    input  logic [7:0] neighbour_draw,
    input  logic [2:0] neighbour_dir,
    input  logic [3:0] neighbour_slot,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_foreground,
    output logic [4:0] match_count
);
    import vbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SELF,
        S_NEIGH,
        S_DONE
    } state_t;

    cfg_t cfg;
    state_t state_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [23:0] colour_reg;
    logic [SlotW-1:0] slot_reg;
    logic [SlotW-1:0] nslot_reg;
    logic self_en_reg;
    logic neigh_en_reg;
    logic [XW+YW-1:0] naddr_reg;
    logic [SlotW:0] issue_reg;
    logic pending_reg;
    logic [CntW-1:0] count_reg;
    logic [17:0] limit_reg;
    logic fg_reg;
    logic [CntW-1:0] res_count_reg;
    logic out_valid_reg;
    logic out_fg_reg;
    logic [4:0] out_count_reg;

    logic ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [AddrW-1:0] ram_raddr;
    logic [23:0] ram_rdata;
    logic in_fire;
    logic in_frame;
    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic n_ok;
    logic hit;
    logic [CntW-1:0] count_next;
    logic stop;

    vbs_cfg u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cfg(cfg)
    );

    vbs_ram #(.Width(24), .Depth(MaxWidth * MaxHeight * Samples)) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(colour_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire = in_valid && !in_stall;
    assign in_frame = ({1'b0, x} < cfg.frame_width) && ({1'b0, y} < cfg.frame_height);
    assign out_valid = out_valid_reg;
    assign is_foreground = out_fg_reg;
    assign match_count = out_count_reg;

    always_comb
    begin
        nx = $signed({2'b00, x});
        ny = $signed({2'b00, y});
        case (neighbour_dir)
            3'd0: begin nx = nx - (XW + 2)'(1); ny = ny + (YW + 2)'(1); end
            3'd1: begin ny = ny + (YW + 2)'(1); end
            3'd2: begin nx = nx + (XW + 2)'(1); ny = ny + (YW + 2)'(1); end
            3'd3: begin nx = nx + (XW + 2)'(1); end
            3'd4: begin nx = nx + (XW + 2)'(1); ny = ny - (YW + 2)'(1); end
            3'd5: begin ny = ny - (YW + 2)'(1); end
            3'd6: begin nx = nx - (XW + 2)'(1); ny = ny - (YW + 2)'(1); end
            default: begin nx = nx - (XW + 2)'(1); end
        endcase
        n_ok = (nx >= 0) && (ny >= 0) && !nx[XW] && !ny[YW]
            && (nx < $signed({1'b0, cfg.frame_width}))
            && (ny < $signed({1'b0, cfg.frame_height}));
    end

    assign ram_raddr = {y_reg, x_reg, issue_reg[SlotW-1:0]};
    assign hit = pending_reg && (dist_sq(ram_rdata, colour_reg) < limit_reg);
    assign count_next = hit ? CntW'(count_reg + 1'b1) : count_reg;
    assign stop = ({{(5 - CntW){1'b0}}, count_next} >= cfg.min_matches)
        || (!pending_reg && issue_reg == (SlotW + 1)'(Samples))
        || (pending_reg && issue_reg == (SlotW + 1)'(Samples) );

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = {y_reg, x_reg, slot_reg};
        if (state_reg == S_SELF && self_en_reg)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_NEIGH && neigh_en_reg)
        begin
            ram_we = 1'b1;
            ram_waddr = {naddr_reg, nslot_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_fg_reg <= 1'b0;
            out_count_reg <= '0;
            pending_reg <= 1'b0;
            issue_reg <= '0;
            count_reg <= '0;
            fg_reg <= 1'b0;
            res_count_reg <= '0;
            self_en_reg <= 1'b0;
            neigh_en_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        x_reg <= x;
                        y_reg <= y;
                        colour_reg <= {red, green, blue};
                        limit_reg <= 18'(cfg.match_radius * cfg.match_radius);
                        naddr_reg <= {ny[YW-1:0], nx[XW-1:0]};
                        nslot_reg <= neighbour_slot;
                        issue_reg <= '0;
                        pending_reg <= 1'b0;
                        count_reg <= '0;
                        fg_reg <= 1'b0;
                        res_count_reg <= '0;
                        if (!in_frame)
                        begin
                            self_en_reg <= 1'b0;
                            neigh_en_reg <= 1'b0;
                            state_reg <= S_DONE;
                        end
                        else if (operation == OP_LOAD)
                        begin
                            slot_reg <= load_slot;
                            self_en_reg <= 1'b1;
                            neigh_en_reg <= 1'b0;
                            state_reg <= S_SELF;
                        end
                        else
                        begin
                            slot_reg <= self_slot;
                            self_en_reg <= (self_draw == 8'd0);
                            neigh_en_reg <= (neighbour_draw == 8'd0) && n_ok;
                            state_reg <= (cfg.min_matches == 5'd0) ? S_SELF : S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    count_reg <= count_next;
                    if (pending_reg && stop)
                    begin
                        pending_reg <= 1'b0;
                        res_count_reg <= count_next;
                        if ({{(5 - CntW){1'b0}}, count_next} < cfg.min_matches)
                        begin
                            fg_reg <= 1'b1;
                            self_en_reg <= 1'b0;
                            neigh_en_reg <= 1'b0;
                        end
                        state_reg <= S_SELF;
                    end
                    else
                    begin
                        pending_reg <= 1'b1;
                        issue_reg <= (SlotW + 1)'(issue_reg + 1'b1);
                    end
                end
                S_SELF:
                begin
                    state_reg <= S_NEIGH;
                end
                S_NEIGH:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_fg_reg <= fg_reg;
                        out_count_reg <= 5'(res_count_reg);
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> rtl/core/vbs_ram.sv
module vbs_ram #(
    parameter int Width = 24,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/vbs_cfg.sv
module vbs_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [8:0]          cfg_data,
    output vbs_pkg::cfg_t       cfg
);
    import vbs_pkg::*;

    cfg_t cfg_reg;
    logic [8:0] subsample_reg;

    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_radius <= 9'd20;
            cfg_reg.min_matches <= 5'd2;
            cfg_reg.frame_width <= 7'd64;
            cfg_reg.frame_height <= 7'd64;
            subsample_reg <= 9'd16;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RADIUS: cfg_reg.match_radius <= cfg_data;
                REG_MIN: cfg_reg.min_matches <= cfg_data[4:0];
                REG_SUBSAMPLE: subsample_reg <= cfg_data;
                REG_WIDTH: cfg_reg.frame_width <= cfg_data[6:0];
                REG_HEIGHT: cfg_reg.frame_height <= cfg_data[6:0];
                default: subsample_reg <= subsample_reg;
            endcase
        end
    end
endmodule

>>> rtl/core/vbs_checker.sv
module vbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       is_foreground,
    input logic [4:0] match_count
);
`include "vibe_background_segmenter_core_assert.svh"
    `VBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `VBS_ASSERT_IMPL(a_count_range, clk, rst_n, out_valid |-> (match_count <= 5'd16))
    `VBS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall,
                     $stable({is_foreground, match_count}))
    `VBS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind vibe_background_segmenter_core vbs_checker u_vbs_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_foreground(is_foreground),
    .match_count(match_count)
);

>>> tb/sv/vibe_background_segmenter_core_tb.sv
`timescale 1ns / 1ps

module vibe_background_segmenter_core_tb;
    import vbs_pkg::*;

    typedef struct packed {
        logic       fg;
        logic [4:0] cnt;
    } verdict_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [2:0] cfg_index;
    logic [8:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       operation;
    logic [5:0] x;
    logic [5:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] load_slot;
    logic [7:0] self_draw;
    logic [3:0] self_slot;
    logic [7:0] neighbour_draw;
    logic [2:0] neighbour_dir;
    logic [3:0] neighbour_slot;
    logic       out_valid;
    logic       out_stall;
    logic       is_foreground;
    logic [4:0] match_count;

    logic [23:0] colour_mem [0:65535];
    bit          loaded_mem [0:65535];
    logic [8:0]  radius_q;
    logic [4:0]  min_q;
    logic [8:0]  subsample_q;
    logic [6:0]  width_q;
    logic [6:0]  height_q;
    verdict_t    verdict_q[$];
    int          errors;
    int          burst_left;
    int          stall_mode;
    int          stall_left;
    int          pool_x[6] = '{0, 1, 2, 31, 62, 63};

    vibe_background_segmenter_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL vibe_background_segmenter_core");
        $finish;
    end

    function automatic int addr_of(int px, int py, int slot);
        return (py * MaxWidth + px) * Samples + slot;
    endfunction

    function automatic bit pixel_ready(int px, int py);
        for (int k = 0; k < Samples; k++)
            if (!loaded_mem[addr_of(px, py, k)])
                return 0;
        return 1;
    endfunction

    function automatic void store_colour(int px, int py, int slot, logic [23:0] c);
        colour_mem[addr_of(px, py, slot)] = c;
        loaded_mem[addr_of(px, py, slot)] = 1;
    endfunction

    function automatic verdict_t classify_pixel();
        verdict_t    v;
        int          w;
        int          h;
        int          cnt;
        int          lim;
        int          d2;
        int          nx;
        int          ny;
        logic [23:0] c;
        logic [23:0] s;
        int          dx[8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
        int          dy[8] = '{1, 1, 1, 0, -1, -1, -1, 0};
        v = '0;
        w = (width_q < MaxWidth) ? width_q : MaxWidth;
        h = (height_q < MaxHeight) ? height_q : MaxHeight;
        c = {red, green, blue};
        if (x >= w || y >= h)
            return v;
        if (operation == OP_LOAD)
        begin
            store_colour(x, y, load_slot, c);
            return v;
        end
        cnt = 0;
        lim = radius_q * radius_q;
        for (int k = 0; k < Samples && cnt < min_q; k++)
        begin
            s = colour_mem[addr_of(x, y, k)];
            d2 = (int'(s[23:16]) - int'(red)) ** 2 + (int'(s[15:8]) - int'(green)) ** 2
                + (int'(s[7:0]) - int'(blue)) ** 2;
            if (d2 < lim)
                cnt++;
        end
        if (cnt < min_q)
            v.fg = 1'b1;
        else
        begin
            if (self_draw == 0)
                store_colour(x, y, self_slot, c);
            if (neighbour_draw == 0)
            begin
                nx = x + dx[neighbour_dir];
                ny = y + dy[neighbour_dir];
                if (nx >= 0 && ny >= 0 && nx < w && ny < h)
                    store_colour(nx, ny, neighbour_slot, c);
            end
        end
        v.cnt = 5'(cnt);
        return v;
    endfunction

    task automatic send_request(logic op, int px, int py, logic [23:0] c, int lslot,
                                int sdraw, int sslot, int ndraw, int ndir, int nslot);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid = 1'b0;
            end
        end
        @(negedge clk);
        in_valid = 1'b1;
        operation = op;
        x = 6'(px);
        y = 6'(py);
        {red, green, blue} = c;
        load_slot = 4'(lslot);
        self_draw = 8'(sdraw);
        self_slot = 4'(sslot);
        neighbour_draw = 8'(ndraw);
        neighbour_dir = 3'(ndir);
        neighbour_slot = 4'(nslot);
        do @(posedge clk); while (in_stall);
        verdict_q.push_back(classify_pixel());
        burst_left--;
    endtask

    task automatic load_request(int px, int py, int slot, logic [23:0] c);
        send_request(OP_LOAD, px, py, c, slot, $urandom_range(0, 255), $urandom_range(0, 15),
                     $urandom_range(0, 255), $urandom_range(0, 7), $urandom_range(0, 15));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = 9'(val);
        case (idx)
            REG_RADIUS: radius_q = 9'(val);
            REG_MIN: min_q = 5'(val);
            REG_SUBSAMPLE: subsample_q = 9'(val);
            REG_WIDTH: width_q = 7'(val);
            REG_HEIGHT: height_q = 7'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_config(int rad, int mn, int sub, int w, int h);
        wait_idle();
        write_reg(REG_RADIUS, rad);
        write_reg(REG_MIN, mn);
        write_reg(REG_SUBSAMPLE, sub);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // Every pixel of the pool gets all of its slots loaded, so that any later
    // segment request on it reads only written colors.
    task automatic test_model_load();
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 6; j++)
                for (int k = 0; k < Samples; k++)
                    load_request(pool_x[i], pool_x[j], k,
                                 (k == 0) ? 24'h000000 : (k == 1) ? 24'hffffff
                                 : 24'($urandom()));
    endtask

    task automatic segment_near(int px, int py, int spread, int sdraw, int ndraw);
        logic [23:0] s;
        logic [23:0] c;
        int          v;
        s = colour_mem[addr_of(px, py, $urandom_range(0, 15))];
        for (int ch = 0; ch < 3; ch++)
        begin
            v = int'(s[ch*8 +: 8]) + $urandom_range(0, 2 * spread) - spread;
            c[ch*8 +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        end
        send_request(OP_SEGMENT, px, py, c, $urandom_range(0, 15), sdraw,
                     $urandom_range(0, 15), ndraw, $urandom_range(0, 7),
                     $urandom_range(0, 15));
    endtask

    task automatic test_directed();
        send_request(OP_SEGMENT, 0, 0, 24'h000000, 0, 0, 15, 0, 0, 15);
        send_request(OP_SEGMENT, 63, 63, 24'hffffff, 15, 0, 0, 0, 2, 0);
        send_request(OP_SEGMENT, 63, 0, 24'h808080, 0, 255, 3, 255, 4, 3);
        for (int d = 0; d < 8; d++)
            send_request(OP_SEGMENT, (d < 4) ? 0 : 63, (d % 2) ? 0 : 63,
                         colour_mem[addr_of((d < 4) ? 0 : 63, (d % 2) ? 0 : 63, 0)],
                         0, 0, d, 0, d, 15 - d);
        set_config(0, 1, 1, 1, 1);
        send_request(OP_SEGMENT, 0, 0, 24'h000000, 0, 0, 0, 0, 1, 0);
        send_request(OP_SEGMENT, 1, 0, 24'h000000, 0, 0, 0, 0, 1, 0);
        send_request(OP_LOAD, 0, 1, 24'h123456, 4, 0, 0, 0, 0, 0);
        set_config(511, 31, 511, 127, 127);
        send_request(OP_SEGMENT, 63, 63, 24'h000000, 0, 0, 1, 0, 6, 2);
        set_config(442, 16, 256, 64, 64);
        send_request(OP_SEGMENT, 31, 31, 24'hff00ff, 0, 0, 5, 0, 7, 9);
        set_config(20, 0, 0, 0, 0);
        send_request(OP_SEGMENT, 2, 2, 24'h00ff00, 0, 0, 0, 0, 0, 0);
        set_config(20, 0, 16, 64, 64);
        send_request(OP_SEGMENT, 2, 2, 24'h00ff00, 0, 0, 6, 0, 3, 6);
    endtask

    task automatic test_random(int n);
        int px;
        int py;
        int sel;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) == 0)
                wait_idle();
            sel = $urandom_range(0, 99);
            px = pool_x[$urandom_range(0, 5)];
            py = pool_x[$urandom_range(0, 5)];
            if (sel < 65)
                segment_near(px, py, $urandom_range(0, 3) == 0 ? 128 : radius_q / 2,
                             ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255),
                             ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255));
            else if (sel < 85)
                load_request(px, py, $urandom_range(0, 15), 24'($urandom()));
            else if (sel < 92)
                load_request($urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 15), 24'($urandom()));
            else
            begin
                px = $urandom_range(0, 63);
                py = $urandom_range(0, 63);
                if (px < width_q && py < height_q && !pixel_ready(px, py))
                begin
                    px = pool_x[$urandom_range(0, 5)];
                    py = pool_x[$urandom_range(0, 5)];
                end
                send_request(OP_SEGMENT, px, py, 24'($urandom()), $urandom_range(0, 15),
                             $urandom_range(0, 255), $urandom_range(0, 15),
                             $urandom_range(0, 255), $urandom_range(0, 7),
                             $urandom_range(0, 15));
            end
        end
    endtask

    task automatic test_config_sweep();
        for (int p = 0; p < 8; p++)
        begin
            set_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                       : $urandom_range(5, 80),
                       $urandom_range(0, 4) == 0 ? $urandom_range(0, 31)
                       : $urandom_range(1, 6),
                       $urandom_range(0, 511),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : 64,
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : 64);
            test_random(35);
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: fg=%0d count=%0d", is_foreground,
                             match_count);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (is_foreground !== want.fg || match_count !== want.cnt)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected fg=%0d count=%0d, got fg=%0d count=%0d",
                                 want.fg, want.cnt, is_foreground, match_count);
                end
            end
        end
    end

    initial
    begin
        burst_left = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_LOAD;
        {x, y, red, green, blue, load_slot, self_draw, self_slot} = '0;
        {neighbour_draw, neighbour_dir, neighbour_slot} = '0;
        radius_q = 20;
        min_q = 2;
        subsample_q = 16;
        width_q = 64;
        height_q = 64;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_model_load();
        test_directed();
        test_random(150);
        test_config_sweep();
        wait_idle();
        repeat (40) @(posedge clk);
        if (errors == 0 && verdict_q.size() == 0)
            $display("PASS vibe_background_segmenter_core");
        else
            $display("FAIL vibe_background_segmenter_core");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/vbs_pkg.sv
rtl/core/vbs_ram.sv
rtl/core/vbs_cfg.sv
rtl/core/vibe_background_segmenter_core.sv
rtl/core/vbs_checker.sv
tb/sv/vibe_background_segmenter_core_tb.sv
